### design/jbt_pkg.sv
// jbt_pkg: shared types and constants for the json byte tokenizer
// no dependencies; used by every module of the block
package jbt_pkg;

   localparam int unsigned QueueDepth = 4;

   // event codes on rsp_event_kind
   localparam logic EV_BYTE = 1'b0;
   localparam logic EV_END  = 1'b1;

   // character codes
   localparam logic [7:0] CH_LBRACK = 8'h5B;
   localparam logic [7:0] CH_RBRACK = 8'h5D;
   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_NL     = 8'h0A;
   localparam logic [7:0] CH_TAB    = 8'h09;

   // events caused by one request, always in the order pre, emit, post
   typedef struct packed {
      logic       pre_close;
      logic       emit;
      logic       post_close;
      logic [7:0] data;
   } plan_type;

   // queue handshake between the stages
   typedef struct packed {
      logic valid;
      logic ready;
   } link_type;

endpackage

### design/jbt_front.sv
// jbt_front: classifies each request byte and tracks quote and token state
// depends on jbt_pkg
module jbt_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic [7:0]        in_byte,
   input  logic              in_last,
   input  logic              accept,
   output jbt_pkg::plan_type plan,
   output logic              plan_valid
);

   logic       in_quotes_ff, in_quotes_in;
   logic       token_open_ff, token_open_in;
   logic [7:0] prev_byte_ff, prev_byte_in;

   logic is_delim, is_space, is_quote;
   logic pre, emit, post, open_after, quotes_after;

   always_comb begin
      is_delim = (in_byte == jbt_pkg::CH_LBRACK) || (in_byte == jbt_pkg::CH_RBRACK) ||
                 (in_byte == jbt_pkg::CH_LBRACE) || (in_byte == jbt_pkg::CH_RBRACE) ||
                 (in_byte == jbt_pkg::CH_COMMA)  || (in_byte == jbt_pkg::CH_COLON);
      is_space = (in_byte == jbt_pkg::CH_SPACE) || (in_byte == jbt_pkg::CH_NL) ||
                 (in_byte == jbt_pkg::CH_TAB);
      is_quote = (in_byte == jbt_pkg::CH_QUOTE);

      pre = 1'b0;
      emit = 1'b0;
      post = 1'b0;
      open_after = token_open_ff;
      quotes_after = in_quotes_ff;
      if (in_quotes_ff) begin
         emit = 1'b1;
         if (is_quote && (prev_byte_ff != jbt_pkg::CH_BSLASH)) begin
            post = 1'b1;
            open_after = 1'b0;
            quotes_after = 1'b0;
         end else begin
            open_after = 1'b1;
         end
      end else if (is_delim) begin
         pre = token_open_ff;
         emit = 1'b1;
         post = 1'b1;
         open_after = 1'b0;
      end else if (is_quote) begin
         pre = token_open_ff;
         emit = 1'b1;
         open_after = 1'b1;
         quotes_after = 1'b1;
      end else if (is_space) begin
         pre = token_open_ff;
         open_after = 1'b0;
      end else begin
         emit = 1'b1;
         open_after = 1'b1;
      end

      // end of text flushes whatever is pending
      if (in_last) begin
         post = post | open_after;
      end

      plan.pre_close = pre;
      plan.emit = emit;
      plan.post_close = post;
      plan.data = in_byte;
      plan_valid = req_valid && (pre || emit || post);

      in_quotes_in = in_quotes_ff;
      token_open_in = token_open_ff;
      prev_byte_in = prev_byte_ff;
      if (accept) begin
         if (in_last) begin
            in_quotes_in = 1'b0;
            token_open_in = 1'b0;
            prev_byte_in = 8'h00;
         end else begin
            in_quotes_in = quotes_after;
            token_open_in = open_after;
            prev_byte_in = in_byte;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_quotes_ff <= 1'b0;
         token_open_ff <= 1'b0;
         prev_byte_ff <= 8'h00;
      end else begin
         in_quotes_ff <= in_quotes_in;
         token_open_ff <= token_open_in;
         prev_byte_ff <= prev_byte_in;
      end
   end

endmodule

### design/jbt_queue.sv
// jbt_queue: small fifo of event plans between front and back
// depends on jbt_pkg
module jbt_queue #(
   parameter int unsigned DEPTH = jbt_pkg::QueueDepth
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  jbt_pkg::plan_type push_data,
   output logic              full,
   input  logic              pop,
   output jbt_pkg::link_type head_link,
   output jbt_pkg::plan_type head_data
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   jbt_pkg::plan_type slot_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   always_comb begin
      full = (count_ff == CNT_W'(DEPTH));
      head_link.valid = (count_ff != '0);
      head_link.ready = pop;
      head_data = slot_ff[rd_ptr_ff];

      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> (count_ff != '0))
      else $error("queue popped while empty");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("queue pushed while full");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count out of range");

endmodule

### design/jbt_back.sv
// jbt_back: expands queued plans into result events behind an output register
// depends on jbt_pkg
module jbt_back (
   input  logic              clock,
   input  logic              reset,
   input  jbt_pkg::link_type head_link,
   input  jbt_pkg::plan_type head_data,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              event_kind,
   output logic [7:0]        token_byte,
   output logic              run_last
);

   logic [2:0] done_ff, done_in;
   logic       valid_ff, valid_in;
   logic       kind_ff, kind_in;
   logic [7:0] byte_ff, byte_in;
   logic       last_ff, last_in;

   logic [2:0] remaining, pick, rest;
   logic       load;

   always_comb begin
      // bit 2 pre close, bit 1 byte, bit 0 post close
      remaining = {head_data.pre_close, head_data.emit, head_data.post_close} & ~done_ff;
      if (remaining[2]) begin
         pick = 3'b100;
      end else if (remaining[1]) begin
         pick = 3'b010;
      end else begin
         pick = 3'b001;
      end
      rest = remaining & ~pick;

      load = head_link.valid && (!valid_ff || rsp_ready);
      pop = load && (rest == 3'b000);

      valid_in = valid_ff;
      kind_in = kind_ff;
      byte_in = byte_ff;
      last_in = last_ff;
      done_in = done_ff;
      if (load) begin
         valid_in = 1'b1;
         kind_in = pick[1] ? jbt_pkg::EV_BYTE : jbt_pkg::EV_END;
         byte_in = pick[1] ? head_data.data : 8'h00;
         last_in = (rest == 3'b000);
         done_in = (rest == 3'b000) ? 3'b000 : (done_ff | pick);
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         done_ff <= 3'b000;
      end else begin
         valid_ff <= valid_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

   assign rsp_valid = valid_ff;
   assign event_kind = kind_ff;
   assign token_byte = byte_ff;
   assign run_last = last_ff;

   a_head_has_work: assert property (@(posedge clock) disable iff (reset)
      head_link.valid |-> (remaining != 3'b000))
      else $error("queued plan has no events left");

   a_end_carries_zero: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && (kind_ff == jbt_pkg::EV_END)) |-> (byte_ff == 8'h00))
      else $error("end event with nonzero byte");

   a_done_clear_when_idle: assert property (@(posedge clock) disable iff (reset)
      !head_link.valid |-> (done_ff == 3'b000))
      else $error("progress mask left set with empty queue");

endmodule

### design/json_byte_tokenizer.sv
// json_byte_tokenizer: top level of the byte stream tokenizer
// depends on jbt_pkg, jbt_front, jbt_queue, jbt_back
//
// Splits a text byte stream into tokens. Each request (one byte plus a last
// flag) yields zero to three results: token bytes (event_kind 0) and a
// token-end event (event_kind 1, token_byte 0); run_last marks the final
// result of each request. Brackets, braces, comma and colon form one-byte
// tokens, whitespace ends a token and is dropped, a double quote opens a
// quoted token closed by a quote not preceded by a backslash, and the last
// flag flushes any open token and returns the state to its reset values.
// A request is taken every cycle while the plan queue has room; the output
// side delivers one result per cycle while rsp_ready takes them, so a request
// that makes two or three results holds the output for each of them, and the
// QUEUE_DEPTH entry queue absorbs those bursts. A request reaches its first
// result through the queue write, then the output register.
module json_byte_tokenizer #(
   parameter int unsigned QUEUE_DEPTH = jbt_pkg::QueueDepth
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   input  logic       req_in_last,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_event_kind,
   output logic [7:0] rsp_token_byte,
   output logic       rsp_run_last
);

   jbt_pkg::plan_type plan;
   jbt_pkg::plan_type head_data;
   jbt_pkg::link_type head_link;
   logic              plan_valid;
   logic              queue_full;
   logic              accept;
   logic              pop;

   // a request is accepted whenever the queue has a free slot; requests
   // that make no result (whitespace with nothing pending) never enter it
   assign req_ready = !queue_full;
   assign accept = req_valid && req_ready;

   // front: classification and token state
   jbt_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .in_byte    (req_in_byte),
      .in_last    (req_in_last),
      .accept     (accept),
      .plan       (plan),
      .plan_valid (plan_valid)
   );

   // decoupling queue of per-request event plans
   jbt_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (plan_valid && req_ready),
      .push_data (plan),
      .full      (queue_full),
      .pop       (pop),
      .head_link (head_link),
      .head_data (head_data)
   );

   // back: one result per cycle into the output register while results are taken
   jbt_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_link  (head_link),
      .head_data  (head_data),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .event_kind (rsp_event_kind),
      .token_byte (rsp_token_byte),
      .run_last   (rsp_run_last)
   );

endmodule
